// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; they compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("property violated");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== rtl/pbe_pkg.sv =====
// ----------------------------------------------------------------------------
// PackBits line encoder package
// Types and fixed constants shared by the encoder modules.
// ----------------------------------------------------------------------------
package pbe_pkg;

    localparam int BYTE_W     = 8;
    localparam int LANES_MAX  = 4;
    localparam int CNT_W      = 3;
    localparam int SEG_BITS   = 7;
    localparam int LIT_ADDR_W = 7;
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = 2;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_RUN,
        MODE_LIT
    } mode_t;

    typedef enum logic [1:0] {
        CMD_PAIR,
        CMD_LIT,
        CMD_END
    } cmd_kind_t;

    typedef enum logic [1:0] {
        BK_FETCH,
        BK_VALUE,
        BK_LIT
    } back_state_t;

    typedef struct packed {
        cmd_kind_t kind;
        byte_t     hdr;
        byte_t     value;
        logic      bank;
        logic      line_done;
    } cmd_t;

    typedef struct packed {
        logic                  en;
        logic                  bank;
        logic [LIT_ADDR_W-1:0] addr;
        byte_t                 data;
    } lit_wr_t;

    typedef struct packed {
        logic done;
        logic bank;
    } lit_status_t;

endpackage

// ===== rtl/pbe_if.sv =====
// ----------------------------------------------------------------------------
// PackBits line encoder channels
// Valid/ready channels for line bytes in and encoded results out.
// ----------------------------------------------------------------------------
interface pbe_byte_if;

    logic           valid;
    logic           ready;
    pbe_pkg::byte_t data_byte;
    logic           line_end;

    modport source (output valid, data_byte, line_end, input ready);
    modport sink (input valid, data_byte, line_end, output ready);

endinterface

interface pbe_block_if;

    logic                      valid;
    logic                      ready;
    pbe_pkg::byte_t            lane0;
    pbe_pkg::byte_t            lane1;
    pbe_pkg::byte_t            lane2;
    pbe_pkg::byte_t            lane3;
    logic [pbe_pkg::CNT_W-1:0] byte_count;
    logic                      line_done;
    logic                      last;

    modport source (output valid, lane0, lane1, lane2, lane3, byte_count, line_done, last,
                    input ready);
    modport sink (input valid, lane0, lane1, lane2, lane3, byte_count, line_done, last,
                  output ready);

endinterface

// ===== rtl/pbe_front.sv =====
// ----------------------------------------------------------------------------
// PackBits block planner
// Accepts line bytes into a three-byte window and decides, one step per cycle
// unless stalled, where runs and literals start and end; literals are stored.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pbe_front #(
    parameter int MAX_BLOCK_BYTES = 127,
    parameter int MAX_LINE_BYTES  = 6144
) (
    input  logic                 clk,
    input  logic                 rst_n,
    pbe_byte_if.sink             line_bytes,
    output pbe_pkg::cmd_t        cmd,
    output logic                 cmd_push,
    input  logic                 cmd_full,
    output pbe_pkg::lit_wr_t     lit_wr,
    input  pbe_pkg::lit_status_t lit_status
);

    localparam int LPW  = $clog2(MAX_LINE_BYTES + 1);
    localparam int LENW = $clog2(MAX_BLOCK_BYTES + 2);
    localparam int PW   = (LPW > pbe_pkg::SEG_BITS) ? LPW : pbe_pkg::SEG_BITS;
    localparam logic [LPW-1:0]  LINE_LIMIT = LPW'(MAX_LINE_BYTES);
    localparam logic [LENW-1:0] BLK_LIMIT  = LENW'(MAX_BLOCK_BYTES);

    typedef enum logic [2:0] {
        ACT_BREAK,
        ACT_CLOSE_RUN,
        ACT_CLOSE_LIT,
        ACT_EXTEND_RUN,
        ACT_STORE_LIT,
        ACT_PAIR,
        ACT_START_RUN,
        ACT_START_LIT
    } act_t;

    pbe_pkg::byte_t  win_reg [3];
    pbe_pkg::byte_t  win_next [3];
    logic [1:0]      wc_reg, wc_next;
    pbe_pkg::mode_t  mode_reg, mode_next;
    logic [LENW-1:0] len_reg, len_next;
    pbe_pkg::byte_t  run_reg, run_next;
    logic [LPW-1:0]  lp_reg, lp_next;
    logic            bank_reg, bank_next;
    logic [1:0]      busy_reg, busy_next;
    logic            open_reg, open_next;
    logic            end_reg, end_next;

    logic [PW-1:0]   pos;
    logic [PW-1:0]   pos_prev;
    logic [LENW-1:0] len_m1;
    logic [LPW-1:0]  lp_inc;
    logic            seg_start;
    logic            run_seg_end;
    logic            eq01, eq12, eq_run;
    logic            wc_zero;
    act_t            act;
    logic            can_do;
    logic            step_go;
    logic            ready;
    logic            accept;

    always_comb
    begin
        pos         = PW'(lp_reg) - PW'(wc_reg);
        pos_prev    = pos - PW'(1);
        seg_start   = (pos[pbe_pkg::SEG_BITS-1:0] == '0);
        run_seg_end = (pos_prev[pbe_pkg::SEG_BITS-1:0] == '0);
        len_m1      = len_reg - LENW'(1);
        eq01        = (win_reg[0] == win_reg[1]);
        eq12        = (win_reg[1] == win_reg[2]);
        eq_run      = (win_reg[0] == run_reg);
        wc_zero     = (wc_reg == 2'd0);

        unique case (mode_reg)
            pbe_pkg::MODE_RUN:
            begin
                if ((len_m1 >= BLK_LIMIT) || run_seg_end || (end_reg && wc_zero))
                    act = ACT_CLOSE_RUN;
                else if (wc_zero)
                    act = ACT_BREAK;
                else if (eq_run)
                    act = ACT_EXTEND_RUN;
                else
                    act = ACT_CLOSE_RUN;
            end
            pbe_pkg::MODE_LIT:
            begin
                if (seg_start || (len_reg >= BLK_LIMIT) || (end_reg && wc_zero))
                    act = ACT_CLOSE_LIT;
                else if (wc_reg == 2'd3)
                    act = (eq01 && eq12) ? ACT_CLOSE_LIT : ACT_STORE_LIT;
                else if (wc_reg == 2'd2)
                    act = (!eq01 || end_reg) ? ACT_STORE_LIT : ACT_BREAK;
                else
                    act = end_reg ? ACT_STORE_LIT : ACT_BREAK;
            end
            default:
            begin
                if (wc_zero)
                    act = ACT_BREAK;
                else if (wc_reg == 2'd1)
                    act = end_reg ? ACT_PAIR : ACT_BREAK;
                else
                    act = eq01 ? ACT_START_RUN : ACT_START_LIT;
            end
        endcase

        unique case (act)
            ACT_BREAK, ACT_CLOSE_RUN, ACT_CLOSE_LIT, ACT_PAIR:
                can_do = !cmd_full;
            ACT_STORE_LIT, ACT_START_LIT:
                can_do = !busy_reg[bank_reg];
            default:
                can_do = 1'b1;
        endcase
    end

    assign step_go          = open_reg && can_do;
    assign ready            = !open_reg || ((act == ACT_BREAK) && !cmd_full);
    assign accept           = line_bytes.valid && ready;
    assign line_bytes.ready = ready;

    always_comb
    begin
        win_next  = win_reg;
        wc_next   = wc_reg;
        mode_next = mode_reg;
        len_next  = len_reg;
        run_next  = run_reg;
        lp_next   = lp_reg;
        bank_next = bank_reg;
        busy_next = busy_reg;
        open_next = open_reg;
        end_next  = end_reg;
        cmd       = '0;
        cmd_push  = 1'b0;
        lit_wr    = '0;
        lp_inc    = '0;

        if (lit_status.done)
            busy_next[lit_status.bank] = 1'b0;

        if (step_go)
        begin
            unique case (act)
                ACT_BREAK:
                begin
                    cmd.kind      = pbe_pkg::CMD_END;
                    cmd.line_done = end_reg;
                    cmd_push      = 1'b1;
                    open_next     = 1'b0;
                    if (end_reg)
                        lp_next = '0;
                end
                ACT_CLOSE_RUN:
                begin
                    cmd.kind  = pbe_pkg::CMD_PAIR;
                    cmd.hdr   = 8'd0 - 8'(len_m1);
                    cmd.value = run_reg;
                    cmd_push  = 1'b1;
                    mode_next = pbe_pkg::MODE_IDLE;
                    len_next  = '0;
                end
                ACT_CLOSE_LIT:
                begin
                    cmd.kind            = pbe_pkg::CMD_LIT;
                    cmd.hdr             = 8'(len_m1);
                    cmd.bank            = bank_reg;
                    cmd_push            = 1'b1;
                    busy_next[bank_reg] = 1'b1;
                    bank_next           = !bank_reg;
                    mode_next           = pbe_pkg::MODE_IDLE;
                    len_next            = '0;
                end
                ACT_EXTEND_RUN:
                begin
                    len_next    = len_reg + LENW'(1);
                    win_next[0] = win_reg[1];
                    win_next[1] = win_reg[2];
                    wc_next     = wc_reg - 2'd1;
                end
                ACT_STORE_LIT:
                begin
                    lit_wr.en   = 1'b1;
                    lit_wr.bank = bank_reg;
                    lit_wr.addr = pbe_pkg::LIT_ADDR_W'(len_reg);
                    lit_wr.data = win_reg[0];
                    len_next    = len_reg + LENW'(1);
                    win_next[0] = win_reg[1];
                    win_next[1] = win_reg[2];
                    wc_next     = wc_reg - 2'd1;
                end
                ACT_PAIR:
                begin
                    cmd.kind    = pbe_pkg::CMD_PAIR;
                    cmd.value   = win_reg[0];
                    cmd_push    = 1'b1;
                    win_next[0] = win_reg[1];
                    win_next[1] = win_reg[2];
                    wc_next     = wc_reg - 2'd1;
                end
                ACT_START_RUN:
                begin
                    mode_next   = pbe_pkg::MODE_RUN;
                    run_next    = win_reg[0];
                    len_next    = LENW'(2);
                    win_next[0] = win_reg[2];
                    wc_next     = wc_reg - 2'd2;
                end
                default:
                begin
                    lit_wr.en   = 1'b1;
                    lit_wr.bank = bank_reg;
                    lit_wr.data = win_reg[0];
                    mode_next   = pbe_pkg::MODE_LIT;
                    len_next    = LENW'(1);
                    win_next[0] = win_reg[1];
                    win_next[1] = win_reg[2];
                    wc_next     = wc_reg - 2'd1;
                end
            endcase
        end

        if (accept)
        begin
            lp_inc = lp_next + LPW'(1);
            unique case (wc_reg)
                2'd0:    win_next[0] = line_bytes.data_byte;
                2'd1:    win_next[1] = line_bytes.data_byte;
                default: win_next[2] = line_bytes.data_byte;
            endcase
            wc_next   = wc_reg + 2'd1;
            lp_next   = lp_inc;
            open_next = 1'b1;
            end_next  = line_bytes.line_end || (lp_inc >= LINE_LIMIT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wc_reg   <= '0;
            mode_reg <= pbe_pkg::MODE_IDLE;
            len_reg  <= '0;
            run_reg  <= '0;
            lp_reg   <= '0;
            bank_reg <= 1'b0;
            busy_reg <= '0;
            open_reg <= 1'b0;
            end_reg  <= 1'b0;
        end
        else
        begin
            wc_reg   <= wc_next;
            mode_reg <= mode_next;
            len_reg  <= len_next;
            run_reg  <= run_next;
            lp_reg   <= lp_next;
            bank_reg <= bank_next;
            busy_reg <= busy_next;
            open_reg <= open_next;
            end_reg  <= end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    `ASSERT_NEVER(a_busy_bank_write, clk, rst_n, lit_wr.en && busy_reg[lit_wr.bank])
    `ASSERT_PROP(a_lit_close_flips_bank, clk, rst_n, (cmd_push && cmd.kind == pbe_pkg::CMD_LIT) |=> (bank_reg != $past(bank_reg)))
    `ASSERT_PROP(a_settled_window, clk, rst_n, !open_reg |-> (wc_reg != 2'd3))

endmodule

// ===== rtl/pbe_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// PackBits command queue
// Short first-in first-out queue of block commands between planner and packer.
// ----------------------------------------------------------------------------
module pbe_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pbe_pkg::cmd_t cmd_in,
    input  logic          pop,
    output pbe_pkg::cmd_t head,
    output logic          empty,
    output logic          full
);

    pbe_pkg::cmd_t                slot_reg [pbe_pkg::CMDQ_DEPTH];
    logic [pbe_pkg::CMDQ_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [pbe_pkg::CMDQ_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [pbe_pkg::CMDQ_AW:0]    count_reg, count_next;
    logic                         do_push;
    logic                         do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == (pbe_pkg::CMDQ_AW + 1)'(pbe_pkg::CMDQ_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + pbe_pkg::CMDQ_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + pbe_pkg::CMDQ_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (pbe_pkg::CMDQ_AW + 1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (pbe_pkg::CMDQ_AW + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= cmd_in;
    end

endmodule

// ===== rtl/pbe_back.sv =====
// ----------------------------------------------------------------------------
// PackBits byte packer
// Executes block commands, reads literal bytes from the two-bank store and
// packs the encoded bytes into results of several lanes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pbe_back #(
    parameter int MAX_BLOCK_BYTES = 127,
    parameter int OUT_LANES       = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pbe_pkg::cmd_t        cmd,
    input  logic                 cmd_empty,
    output logic                 cmd_pop,
    input  pbe_pkg::lit_wr_t     lit_wr,
    output pbe_pkg::lit_status_t lit_status,
    pbe_block_if.source          packed_bytes
);

    localparam int LIT_AW = $clog2(MAX_BLOCK_BYTES);
    localparam int CNT_W  = pbe_pkg::CNT_W;

    pbe_pkg::byte_t       lit_mem [2 ** (LIT_AW + 1)];
    pbe_pkg::byte_t       rd_data_reg;
    logic                 rd_en;
    logic [LIT_AW:0]      rd_addr;

    pbe_pkg::back_state_t bstate_reg, bstate_next;
    pbe_pkg::byte_t       value_reg, value_next;
    logic                 bank_reg, bank_next;
    logic [LIT_AW-1:0]    idx_reg, idx_next;
    logic [LIT_AW-1:0]    last_idx_reg, last_idx_next;

    pbe_pkg::byte_t       acc_reg [pbe_pkg::LANES_MAX];
    pbe_pkg::byte_t       acc_next [pbe_pkg::LANES_MAX];
    logic [CNT_W-1:0]     acc_cnt_reg, acc_cnt_next;

    logic                 out_valid_reg, out_valid_next;
    pbe_pkg::byte_t       lane_reg [pbe_pkg::LANES_MAX];
    pbe_pkg::byte_t       load_lane [pbe_pkg::LANES_MAX];
    logic [CNT_W-1:0]     cnt_reg;
    logic                 done_reg;
    logic                 last_reg;

    logic                 out_free;
    logic                 acc_full;
    logic                 push_req;
    logic                 push_ok;
    pbe_pkg::byte_t       push_byte;
    logic                 flush;
    logic                 out_load;
    logic                 load_last;
    logic                 load_done;

    assign out_free = !out_valid_reg || packed_bytes.ready;
    assign acc_full = (acc_cnt_reg == CNT_W'(OUT_LANES));
    assign push_ok  = !acc_full || out_free;

    always_comb
    begin
        bstate_next   = bstate_reg;
        value_next    = value_reg;
        bank_next     = bank_reg;
        idx_next      = idx_reg;
        last_idx_next = last_idx_reg;
        push_req      = 1'b0;
        push_byte     = '0;
        flush         = 1'b0;
        cmd_pop       = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = '0;
        lit_status    = '0;

        unique case (bstate_reg)
            pbe_pkg::BK_FETCH:
            begin
                if (!cmd_empty)
                begin
                    unique case (cmd.kind)
                        pbe_pkg::CMD_END:
                        begin
                            if (out_free)
                            begin
                                flush   = 1'b1;
                                cmd_pop = 1'b1;
                            end
                        end
                        pbe_pkg::CMD_PAIR:
                        begin
                            push_req  = 1'b1;
                            push_byte = cmd.hdr;
                            if (push_ok)
                            begin
                                cmd_pop     = 1'b1;
                                value_next  = cmd.value;
                                bstate_next = pbe_pkg::BK_VALUE;
                            end
                        end
                        pbe_pkg::CMD_LIT:
                        begin
                            push_req  = 1'b1;
                            push_byte = cmd.hdr;
                            if (push_ok)
                            begin
                                cmd_pop       = 1'b1;
                                rd_en         = 1'b1;
                                rd_addr       = {cmd.bank, LIT_AW'(0)};
                                bank_next     = cmd.bank;
                                idx_next      = '0;
                                last_idx_next = cmd.hdr[LIT_AW-1:0];
                                bstate_next   = pbe_pkg::BK_LIT;
                            end
                        end
                        default:
                            cmd_pop = 1'b1;
                    endcase
                end
            end
            pbe_pkg::BK_VALUE:
            begin
                push_req  = 1'b1;
                push_byte = value_reg;
                if (push_ok)
                    bstate_next = pbe_pkg::BK_FETCH;
            end
            pbe_pkg::BK_LIT:
            begin
                push_req  = 1'b1;
                push_byte = rd_data_reg;
                if (push_ok)
                begin
                    if (idx_reg == last_idx_reg)
                    begin
                        lit_status.done = 1'b1;
                        lit_status.bank = bank_reg;
                        bstate_next     = pbe_pkg::BK_FETCH;
                    end
                    else
                    begin
                        idx_next = idx_reg + LIT_AW'(1);
                        rd_en    = 1'b1;
                        rd_addr  = {bank_reg, idx_reg + LIT_AW'(1)};
                    end
                end
            end
            default:
                bstate_next = pbe_pkg::BK_FETCH;
        endcase
    end

    always_comb
    begin
        for (int j = 0; j < pbe_pkg::LANES_MAX; j++)
        begin
            load_lane[j] = (CNT_W'(j) < acc_cnt_reg) ? acc_reg[j] : '0;
        end

        acc_next       = acc_reg;
        acc_cnt_next   = acc_cnt_reg;
        out_load       = 1'b0;
        load_last      = 1'b0;
        load_done      = 1'b0;

        if (flush)
        begin
            out_load     = 1'b1;
            load_last    = 1'b1;
            load_done    = cmd.line_done;
            acc_cnt_next = '0;
        end
        else if (push_req && push_ok)
        begin
            if (acc_full)
            begin
                out_load     = 1'b1;
                acc_next[0]  = push_byte;
                acc_cnt_next = CNT_W'(1);
            end
            else
            begin
                acc_next[acc_cnt_reg[1:0]] = push_byte;
                acc_cnt_next               = acc_cnt_reg + CNT_W'(1);
            end
        end

        if (out_load)
            out_valid_next = 1'b1;
        else if (packed_bytes.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bstate_reg    <= pbe_pkg::BK_FETCH;
            acc_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bstate_reg    <= bstate_next;
            acc_cnt_reg   <= acc_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        bank_reg     <= bank_next;
        idx_reg      <= idx_next;
        last_idx_reg <= last_idx_next;
        acc_reg      <= acc_next;
        if (out_load)
        begin
            lane_reg <= load_lane;
            cnt_reg  <= acc_cnt_reg;
            done_reg <= load_done;
            last_reg <= load_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lit_wr.en)
            lit_mem[{lit_wr.bank, lit_wr.addr[LIT_AW-1:0]}] <= lit_wr.data;
        if (rd_en)
            rd_data_reg <= lit_mem[rd_addr];
    end

    assign packed_bytes.valid      = out_valid_reg;
    assign packed_bytes.lane0      = lane_reg[0];
    assign packed_bytes.lane1      = lane_reg[1];
    assign packed_bytes.lane2      = lane_reg[2];
    assign packed_bytes.lane3      = lane_reg[3];
    assign packed_bytes.byte_count = cnt_reg;
    assign packed_bytes.line_done  = done_reg;
    assign packed_bytes.last       = last_reg;

    `ASSERT_NEVER(a_acc_overfill, clk, rst_n, acc_cnt_reg > CNT_W'(OUT_LANES))
    `ASSERT_NEVER(a_no_result_overwrite, clk, rst_n, out_load && out_valid_reg && !packed_bytes.ready)
    `ASSERT_PROP(a_lit_index_bound, clk, rst_n, (bstate_reg == pbe_pkg::BK_LIT) |-> (idx_reg <= last_idx_reg))

endmodule

// ===== rtl/packbits_line_encoder.sv =====
// ----------------------------------------------------------------------------
// PackBits line encoder
// Throughput: one planner step per cycle unless stalled; a new line byte is
// taken only when the planner has nothing more to do with the bytes it holds.
// A result waits behind any earlier literal of up to 127 bytes, which drains
// one encoded byte per cycle while the output is not stalled.
// Reset clears all control state at once; the literal store is not cleared.
// ----------------------------------------------------------------------------
module packbits_line_encoder #(
    parameter int MAX_BLOCK_BYTES = 127,
    parameter int MAX_LINE_BYTES  = 6144,
    parameter int OUT_LANES       = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    pbe_byte_if.sink    line_bytes,
    pbe_block_if.source packed_bytes
);

    pbe_pkg::cmd_t        push_cmd;
    pbe_pkg::cmd_t        head_cmd;
    logic                 cmd_push;
    logic                 cmd_pop;
    logic                 cmd_full;
    logic                 cmd_empty;
    pbe_pkg::lit_wr_t     lit_wr;
    pbe_pkg::lit_status_t lit_status;

    pbe_front #(
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES),
        .MAX_LINE_BYTES  (MAX_LINE_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_bytes (line_bytes),
        .cmd        (push_cmd),
        .cmd_push   (cmd_push),
        .cmd_full   (cmd_full),
        .lit_wr     (lit_wr),
        .lit_status (lit_status)
    );

    pbe_cmd_fifo u_cmd_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (cmd_push),
        .cmd_in (push_cmd),
        .pop    (cmd_pop),
        .head   (head_cmd),
        .empty  (cmd_empty),
        .full   (cmd_full)
    );

    pbe_back #(
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES),
        .OUT_LANES       (OUT_LANES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (head_cmd),
        .cmd_empty    (cmd_empty),
        .cmd_pop      (cmd_pop),
        .lit_wr       (lit_wr),
        .lit_status   (lit_status),
        .packed_bytes (packed_bytes)
    );

endmodule

// ===== sim/pbe_block_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PackBits line encoder result checker
// Watches both channels. Each accepted line byte is run through a local
// PackBits encoder that keeps its own lookahead window, block state and
// position in the line. The encoded bytes are cut into four-lane results and
// queued. Each accepted output result is then compared field by field with
// the oldest queued result.
// ----------------------------------------------------------------------------
module pbe_block_checker #(
    parameter int MAX_BLOCK_BYTES = 127,
    parameter int MAX_LINE_BYTES  = 6144,
    parameter int OUT_LANES       = 4
) (
    input  logic clk,
    input  logic rst_n,
    pbe_byte_if  line_bytes,
    pbe_block_if packed_bytes,
    output int   mismatches,
    output int   outstanding
);

    localparam int SEG_BYTES = 128;

    typedef struct {
        pbe_pkg::byte_t            lanes [4];
        logic [pbe_pkg::CNT_W-1:0] byte_count;
        logic                      line_done;
        logic                      last;
    } block_t;

    block_t pending_blocks [$];
    block_t want;

    pbe_pkg::byte_t  lit_store [128];
    pbe_pkg::byte_t  look_bytes [2];
    int              look_count;
    pbe_pkg::mode_t  mode;
    int              blk_len;
    pbe_pkg::byte_t  run_val;
    int              line_pos;

    pbe_pkg::byte_t  win [3];
    int              win_cnt;
    pbe_pkg::byte_t  encoded [$];

    function automatic void clear_encoder();
        foreach (lit_store[i])
            lit_store[i] = 8'h00;
        look_bytes[0] = 8'h00;
        look_bytes[1] = 8'h00;
        look_count    = 0;
        mode          = pbe_pkg::MODE_IDLE;
        blk_len       = 0;
        run_val       = 8'h00;
        line_pos      = 0;
        win_cnt       = 0;
        encoded.delete();
    endfunction

    function automatic void shift_window();
        win[0] = win[1];
        win[1] = win[2];
        if (win_cnt > 0)
            win_cnt--;
    endfunction

    function automatic void close_run();
        encoded.push_back(pbe_pkg::byte_t'(256 - (blk_len - 1)));
        encoded.push_back(run_val);
        mode    = pbe_pkg::MODE_IDLE;
        blk_len = 0;
    endfunction

    function automatic void close_literal();
        encoded.push_back(pbe_pkg::byte_t'(blk_len - 1));
        for (int i = 0; i < blk_len; i++)
            encoded.push_back(lit_store[i & 127]);
        mode    = pbe_pkg::MODE_IDLE;
        blk_len = 0;
    endfunction

    function automatic void cut_blocks(input bit final_step);
        int pos;
        int run_end;
        bit triple;
        bit stop;
        stop = 1'b0;
        while (!stop)
        begin
            pos = line_pos - win_cnt;
            case (mode)
                pbe_pkg::MODE_RUN:
                begin
                    run_end = pos - 1;
                    if (blk_len - 1 >= MAX_BLOCK_BYTES || run_end % SEG_BYTES == 0 ||
                        (final_step && win_cnt == 0))
                        close_run();
                    else if (win_cnt == 0)
                        stop = 1'b1;
                    else if (win[0] == run_val)
                    begin
                        blk_len++;
                        shift_window();
                    end
                    else
                        close_run();
                end
                pbe_pkg::MODE_LIT:
                begin
                    if (pos % SEG_BYTES == 0 || blk_len >= MAX_BLOCK_BYTES ||
                        (final_step && win_cnt == 0))
                        close_literal();
                    else
                    begin
                        triple = 1'b0;
                        if (win_cnt >= 3)
                            triple = (win[0] == win[1]) && (win[1] == win[2]);
                        else if (win_cnt == 2 && win[0] == win[1] && !final_step)
                            stop = 1'b1;
                        else if (win_cnt < 2 && !final_step)
                            stop = 1'b1;
                        if (!stop)
                        begin
                            if (triple)
                                close_literal();
                            else
                            begin
                                lit_store[blk_len & 127] = win[0];
                                blk_len++;
                                shift_window();
                            end
                        end
                    end
                end
                default:
                begin
                    mode = pbe_pkg::MODE_IDLE;
                    if (win_cnt == 0)
                        stop = 1'b1;
                    else if (win_cnt == 1)
                    begin
                        if (!final_step)
                            stop = 1'b1;
                        else
                        begin
                            encoded.push_back(8'h00);
                            encoded.push_back(win[0]);
                            shift_window();
                        end
                    end
                    else if (win[0] == win[1])
                    begin
                        mode    = pbe_pkg::MODE_RUN;
                        run_val = win[0];
                        blk_len = 2;
                        shift_window();
                        shift_window();
                    end
                    else
                    begin
                        mode         = pbe_pkg::MODE_LIT;
                        lit_store[0] = win[0];
                        blk_len      = 1;
                        shift_window();
                    end
                end
            endcase
        end
    endfunction

    function automatic void encode_line_byte(input pbe_pkg::byte_t data,
                                             input logic line_end_in);
        bit     line_over;
        int     n_res;
        int     base;
        int     cnt;
        block_t blk;
        win[0]  = look_bytes[0];
        win[1]  = look_bytes[1];
        win_cnt = (look_count > 2) ? 2 : look_count;
        win[win_cnt] = data;
        win_cnt++;
        line_pos++;
        line_over = line_end_in;
        if (line_pos >= MAX_LINE_BYTES)
            line_over = 1'b1;
        encoded.delete();
        cut_blocks(line_over);
        if (line_over)
        begin
            line_pos = 0;
            mode     = pbe_pkg::MODE_IDLE;
            blk_len  = 0;
            win_cnt  = 0;
        end
        look_bytes[0] = (win_cnt > 0) ? win[0] : 8'h00;
        look_bytes[1] = (win_cnt > 1) ? win[1] : 8'h00;
        look_count    = win_cnt;
        n_res = (encoded.size() + OUT_LANES - 1) / OUT_LANES;
        if (n_res == 0)
            n_res = 1;
        for (int k = 0; k < n_res; k++)
        begin
            base = k * OUT_LANES;
            cnt  = (encoded.size() > base) ? encoded.size() - base : 0;
            if (cnt > OUT_LANES)
                cnt = OUT_LANES;
            for (int j = 0; j < 4; j++)
                blk.lanes[j] = (j < cnt) ? encoded[base + j] : 8'h00;
            blk.byte_count = cnt[pbe_pkg::CNT_W-1:0];
            blk.line_done  = line_over && (k == n_res - 1);
            blk.last       = (k == n_res - 1);
            pending_blocks.push_back(blk);
        end
    endfunction

    function automatic void check_field(input string field, input int exp_val,
                                        input int act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, exp_val, act_val);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_encoder();
            pending_blocks.delete();
            mismatches  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (packed_bytes.valid && packed_bytes.ready)
            begin
                if (pending_blocks.size() == 0)
                begin
                    $display("%0t: result with none expected, actual %h %h %h %h count %0d",
                             $time, packed_bytes.lane0, packed_bytes.lane1,
                             packed_bytes.lane2, packed_bytes.lane3, packed_bytes.byte_count);
                    mismatches++;
                end
                else
                begin
                    want = pending_blocks.pop_front();
                    check_field("lane0", want.lanes[0], packed_bytes.lane0);
                    check_field("lane1", want.lanes[1], packed_bytes.lane1);
                    check_field("lane2", want.lanes[2], packed_bytes.lane2);
                    check_field("lane3", want.lanes[3], packed_bytes.lane3);
                    check_field("byte_count", want.byte_count, packed_bytes.byte_count);
                    check_field("line_done", want.line_done, packed_bytes.line_done);
                    check_field("last", want.last, packed_bytes.last);
                end
            end
            if (line_bytes.valid && line_bytes.ready)
                encode_line_byte(line_bytes.data_byte, line_bytes.line_end);
            outstanding <= pending_blocks.size();
        end
    end

endmodule

// ===== sim/packbits_line_encoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PackBits line encoder testbench
// Sends short directed lines, then random lines built from runs and literals,
// some long enough to reach the block size limits and the 128-byte position
// boundaries. Both sides stall in random bursts until the final stretch,
// which has no random stalls. A separate checker predicts and compares every
// result.
// ----------------------------------------------------------------------------
module packbits_line_encoder_tb;

    localparam int MAX_BLOCK_BYTES = 127;
    localparam int MAX_LINE_BYTES  = 6144;
    localparam int OUT_LANES       = 4;
    localparam int STALL_LIMIT     = 4000;
    localparam int ITEMS_STALLED   = 110;
    localparam int ITEMS_TOTAL     = 150;

    logic clk = 1'b0;
    logic rst_n;
    bit   quiet_tail = 1'b0;
    int   items_sent = 0;
    int   stall_cycles = 0;
    int   mismatches;
    int   outstanding;
    pbe_pkg::byte_t line_buf [$];

    pbe_byte_if  line_bytes ();
    pbe_block_if packed_bytes ();

    packbits_line_encoder #(
        .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES),
        .MAX_LINE_BYTES (MAX_LINE_BYTES),
        .OUT_LANES      (OUT_LANES)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .line_bytes  (line_bytes),
        .packed_bytes(packed_bytes)
    );

    pbe_block_checker #(
        .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES),
        .MAX_LINE_BYTES (MAX_LINE_BYTES),
        .OUT_LANES      (OUT_LANES)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .line_bytes  (line_bytes),
        .packed_bytes(packed_bytes),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    task automatic send_byte(input pbe_pkg::byte_t value, input logic is_end);
        line_bytes.valid     <= 1'b1;
        line_bytes.data_byte <= value;
        line_bytes.line_end  <= is_end;
        @(posedge clk);
        while (!line_bytes.ready)
            @(posedge clk);
        items_sent++;
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            line_bytes.valid <= 1'b0;
            repeat ($urandom_range(1, 18))
                @(posedge clk);
        end
    endtask

    task automatic send_line();
        for (int i = 0; i < line_buf.size(); i++)
            send_byte(line_buf[i], i == line_buf.size() - 1);
        line_buf.delete();
    endtask

    task automatic wait_all_results();
        line_bytes.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    function automatic void add_run(input int len, input pbe_pkg::byte_t value);
        for (int i = 0; i < len; i++)
            line_buf.push_back(value);
    endfunction

    function automatic void add_literal(input int len, input bit narrow);
        for (int i = 0; i < len; i++)
            line_buf.push_back(narrow ? pbe_pkg::byte_t'($urandom_range(0, 1))
                                      : pbe_pkg::byte_t'($urandom_range(0, 255)));
    endfunction

    function automatic void add_directed(input pbe_pkg::byte_t values [$]);
        line_buf = values;
    endfunction

    task automatic send_random_line();
        int segs;
        if ($urandom_range(0, 9) < 7)
        begin
            segs = $urandom_range(1, 6);
            repeat (segs)
            begin
                case ($urandom_range(0, 7))
                    0:       add_run($urandom_range(2, 140),
                                     pbe_pkg::byte_t'($urandom_range(0, 255)));
                    1, 2, 3: add_run($urandom_range(2, 6),
                                     pbe_pkg::byte_t'($urandom_range(0, 255)));
                    default: add_literal($urandom_range(1, 12), $urandom_range(0, 1));
                endcase
            end
        end
        else
            add_literal($urandom_range(1, 24), $urandom_range(0, 1));
        send_line();
        if ($urandom_range(0, 7) == 0)
            wait_all_results();
    endtask

    initial
    begin
        packed_bytes.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!quiet_tail && $urandom_range(0, 3) == 0)
            begin
                packed_bytes.ready <= 1'b0;
                repeat ($urandom_range(1, 18))
                    @(posedge clk);
            end
            packed_bytes.ready <= 1'b1;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((line_bytes.valid && line_bytes.ready) ||
                (packed_bytes.valid && packed_bytes.ready))
                stall_cycles <= 0;
            else if (stall_cycles == STALL_LIMIT)
            begin
                $display("packbits_line_encoder_tb failed");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        rst_n                <= 1'b0;
        line_bytes.valid     <= 1'b0;
        line_bytes.data_byte <= 8'h00;
        line_bytes.line_end  <= 1'b0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;

        add_directed('{8'h00});
        send_line();
        add_directed('{8'hFF, 8'hFF});
        send_line();
        add_directed('{8'h80, 8'h7F});
        send_line();
        add_directed('{8'h01, 8'h02, 8'h03, 8'h03, 8'h03, 8'h04});
        send_line();
        add_directed('{8'h55, 8'h55, 8'h55, 8'hAA});
        send_line();
        add_directed('{8'h12, 8'h34, 8'h56, 8'h56});
        send_line();
        add_directed('{8'hC3, 8'hC3, 8'h3C});
        send_line();
        wait_all_results();

        while (items_sent < ITEMS_STALLED)
            send_random_line();
        wait_all_results();

        quiet_tail = 1'b1;
        while (items_sent < ITEMS_TOTAL)
            send_random_line();

        wait_all_results();
        repeat (150)
            @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("packbits_line_encoder_tb passed");
        else
            $display("packbits_line_encoder_tb failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/pbe_pkg.sv
rtl/pbe_if.sv
rtl/pbe_front.sv
rtl/pbe_cmd_fifo.sv
rtl/pbe_back.sv
rtl/packbits_line_encoder.sv
sim/pbe_block_checker.sv
sim/packbits_line_encoder_tb.sv
